// File: rtl/core/periodic_task_due_scheduler_top_macros.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef PERIODIC_TASK_DUE_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_TASK_DUE_SCHEDULER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// ante true now implies cons true in the same cycle
`define PTDS_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// ante true now implies cons true in the next cycle
`define PTDS_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define PTDS_CHECK_NOW(lbl, ante, cons)
`define PTDS_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/ptds_pkg.sv
`default_nettype none

package ptds_pkg;

  localparam int NUM_SLOTS     = 5;
  localparam int TASKS_DEFAULT = 5;
  localparam int NOW_W         = 32;
  localparam int PERIOD_W      = 16;
  localparam int MASK_W        = 5;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int SLOT_IDX_W    = 3;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = 5;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET [NUM_SLOTS] =
    '{16'd10, 16'd10, 16'd10, 16'd10, 16'd100};

  typedef struct packed {
    logic capture;   // item accepted: latch time, clear mask, rewind slot
    logic load;      // fetch slot, form elapsed time, arm divider
    logic step;      // one restoring division step
    logic store;     // write back last-run time and due bit, advance slot
    logic out_load;  // move mask into result register
  } ptds_cmd_t;

  typedef struct packed {
    logic last_slot;
    logic div_done;
  } ptds_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ptds_req_if.sv
`default_nettype none

interface ptds_req_if import ptds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, mode, now_ms, input ready);
  modport sink (input valid, mode, now_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ptds_rsp_if.sv
`default_nettype none

interface ptds_rsp_if import ptds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] due_mask;

  modport source (output valid, due_mask, input ready);
  modport sink (input valid, due_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ptds_cfg_if.sv
`default_nettype none

interface ptds_cfg_if import ptds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ptds_dp.sv
`default_nettype none
`include "periodic_task_due_scheduler_top_macros.svh"

module ptds_dp import ptds_pkg::*; #(
  parameter int TASKS = TASKS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ptds_cmd_t             cmd,
  output      ptds_sts_t             sts,
  input  wire logic                  in_mode,
  input  wire logic [NOW_W-1:0]      in_now,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output      logic [MASK_W-1:0]     due_mask
);

  localparam int SLOT_W = (TASKS > 1) ? $clog2(TASKS) : 1;

  logic [PERIOD_W-1:0]  period_q [NUM_SLOTS];
  logic [NOW_W-1:0]     last_q [TASKS];
  logic [NOW_W-1:0]     now_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [NOW_W-1:0]     quo_r;
  logic [PERIOD_W-1:0]  rem_r;
  logic [PERIOD_W-1:0]  period_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 due_r;
  logic [MASK_W-1:0]    mask_acc;

  logic [PERIOD_W-1:0]  period_sel;
  logic [PERIOD_W-1:0]  period_eff;
  logic [NOW_W-1:0]     elapsed;
  logic [PERIOD_W:0]    trial;
  logic                 trial_ge;
  logic [PERIOD_W-1:0]  rem_next;

  always_comb begin
    period_sel = period_q[SLOT_IDX_W'(slot_r)];
    // zero period behaves as one
    period_eff = (period_sel == '0) ? PERIOD_W'(1) : period_sel;
    elapsed    = now_r - last_q[slot_r];
    trial      = {rem_r, quo_r[NOW_W-1]};
    trial_ge   = trial >= {1'b0, period_r};
    rem_next   = trial_ge ? PERIOD_W'(trial - {1'b0, period_r}) : trial[PERIOD_W-1:0];
    sts.last_slot = slot_r == SLOT_W'(TASKS - 1);
    sts.div_done  = cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  end

  // period registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_q[i] <= PERIOD_RESET[i];
      end
    end else if (cfg_we && (cfg_addr < CFG_ADDR_W'(NUM_SLOTS))) begin
      period_q[cfg_addr] <= cfg_data;
    end
  end

  // last-run times
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASKS; i++) begin
        last_q[i] <= '0;
      end
    end else if (cmd.capture && (in_mode == MODE_START)) begin
      for (int i = 0; i < TASKS; i++) begin
        last_q[i] <= in_now;
      end
    end else if (cmd.store && due_r) begin
      // last + floor(elapsed/p)*p == now - (elapsed mod p)
      last_q[slot_r] <= now_r - NOW_W'(rem_r);
    end
  end

  // sequencing and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_r   <= '0;
      mask_acc <= '0;
      due_mask <= '0;
    end else begin
      if (cmd.capture) begin
        slot_r   <= '0;
        mask_acc <= '0;
      end
      if (cmd.store) begin
        slot_r <= slot_r + SLOT_W'(1);
        if (due_r) begin
          mask_acc <= mask_acc | (MASK_W'(1) << slot_r);
        end
      end
      if (cmd.out_load) begin
        due_mask <= mask_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r <= in_now;
    end
    if (cmd.load) begin
      quo_r    <= elapsed;
      rem_r    <= '0;
      period_r <= period_eff;
      cnt_r    <= '0;
      due_r    <= elapsed >= NOW_W'(period_eff);
    end else if (cmd.step) begin
      quo_r <= {quo_r[NOW_W-2:0], 1'b0};
      rem_r <= rem_next;
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  `PTDS_CHECK_NEXT(a_rem_below_period, cmd.step, rem_r < period_r)
  `PTDS_CHECK_NEXT(a_start_sets_time, cmd.capture && (in_mode == MODE_START), last_q[0] == $past(in_now))
  `PTDS_CHECK_NEXT(a_phase_kept, cmd.store && due_r && (slot_r == '0), (now_r - last_q[0]) < NOW_W'(period_r))
  `PTDS_CHECK_NOW(a_idle_slots_clear, 1'b1, (mask_acc >> TASKS) == '0)

endmodule

`default_nettype wire

// File: rtl/core/ptds_ctrl.sv
`default_nettype none
`include "periodic_task_due_scheduler_top_macros.svh"

module ptds_ctrl import ptds_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire logic      in_mode,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      ptds_cmd_t cmd,
  input  wire ptds_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_STORE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   out_valid_next;

  always_comb begin
    in_ready   = state == S_IDLE;
    in_fire    = in_valid && in_ready;
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.capture = in_fire;
        if (in_fire) begin
          state_next = (in_mode == MODE_START) ? S_DONE : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = sts.last_slot ? S_DONE : S_LOAD;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `PTDS_CHECK_NEXT(a_start_skips_div, in_fire && (in_mode == MODE_START), state == S_DONE)
  `PTDS_CHECK_NEXT(a_last_store_ends, (state == S_STORE) && sts.last_slot, state == S_DONE)
  `PTDS_CHECK_NEXT(a_div_runs_on, (state == S_DIV) && !sts.div_done, state == S_DIV)

endmodule

`default_nettype wire

// File: rtl/core/periodic_task_due_scheduler_top.sv
// Sequence: a start item goes from acceptance straight to S_DONE; a tick item runs
//   S_LOAD, the 32-step divider and S_STORE for each slot before it reaches S_DONE.
// Items: one at a time; S_DONE holds while the result register is still full, and
//   the next item waits until the mask is in the result register.
// Reset: synchronous, active high; periods return to 10,10,10,10,100 ms and all
//   last-run times to zero.
`default_nettype none

module periodic_task_due_scheduler_top import ptds_pkg::*; #(
  parameter int TASKS = TASKS_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  ptds_req_if.sink   req,
  ptds_rsp_if.source rsp,
  ptds_cfg_if.sink   cfg
);

  // Flow of one tick item:
  //   accept -> for each active slot: load (elapsed = now - last),
  //   32 restoring division steps for elapsed mod period, store
  //   (last = now - remainder when due) -> move mask to result register.
  // A start item writes every active last-run time in its accept cycle.

  ptds_cmd_t cmd;
  ptds_sts_t sts;
  logic      in_ready;
  logic      out_valid;

  // period registers take a write in any cycle
  assign cfg.ready = 1'b1;
  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  ptds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .in_mode   (req.mode),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ptds_dp #(
    .TASKS (TASKS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_mode  (req.mode),
    .in_now   (req.now_ms),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_addr (cfg.addr),
    .cfg_data (cfg.data),
    .due_mask (rsp.due_mask)
  );

endmodule

`default_nettype wire

// File: tb/sv/due_mask_checker.sv
module due_mask_checker import ptds_pkg::*; #(
  parameter int TASKS = TASKS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  ptds_req_if  req,
  ptds_rsp_if  rsp,
  ptds_cfg_if  cfg,
  output int   mismatch_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PERIOD_W-1:0] period_q   [NUM_SLOTS];
  logic [NOW_W-1:0]    last_run_q [NUM_SLOTS];
  logic [MASK_W-1:0]   due_mask_q [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Advance the per-slot timers for one item and return the due mask.
  function automatic logic [MASK_W-1:0] advance_timers(input logic mode,
                                                       input logic [NOW_W-1:0] now);
    logic [MASK_W-1:0] mask;
    logic [NOW_W-1:0]  elapsed;
    logic [NOW_W-1:0]  period;
    mask = '0;
    for (int s = 0; s < NUM_SLOTS && s < TASKS; s++) begin
      if (mode == MODE_START) begin
        last_run_q[s] = now;
      end else begin
        period = NOW_W'(period_q[s]);
        if (period == '0) period = NOW_W'(1);
        elapsed = now - last_run_q[s];
        if (elapsed >= period) begin
          // skip missed periods, keep the phase
          last_run_q[s] = last_run_q[s] + (elapsed / period) * period;
          mask[s] = 1'b1;
        end
      end
    end
    return mask;
  endfunction

  always @(posedge clk) begin : monitor
    logic [MASK_W-1:0] want;
    if (rst) begin
      period_q = PERIOD_RESET;
      for (int s = 0; s < NUM_SLOTS; s++) last_run_q[s] = '0;
      due_mask_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_mask_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result due_mask=%b", rsp.due_mask));
        end else begin
          want = due_mask_q.pop_front();
          if (rsp.due_mask !== want)
            report_mismatch($sformatf("due_mask got %b want %b", rsp.due_mask, want));
        end
      end
      if (cfg.valid && cfg.ready && cfg.addr < NUM_SLOTS) period_q[cfg.addr] = cfg.data;
      if (req.valid && req.ready) due_mask_q.push_back(advance_timers(req.mode, req.now_ms));
    end
    pending_count = due_mask_q.size();
  end

endmodule

// File: tb/sv/tb_periodic_task_due_scheduler_top.sv
module tb_periodic_task_due_scheduler_top import ptds_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog: cycles in a row with no item moving on any channel.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settle time after the last result, a bit more than one tick item.
  localparam int DRAIN_CYCLES   = 200;
  localparam int SEGMENT_ITEMS  = 290;
  localparam int START_PCT      = 5;

  typedef enum int {SET_SMALL, SET_EXTREME, SET_FULL, SET_MEDIUM} period_set_t;

  logic clk;
  logic rst;

  ptds_req_if req_ch ();
  ptds_rsp_if rsp_ch ();
  ptds_cfg_if cfg_ch ();

  int mismatch_count;
  int pending_count;

  // Idle rates in percent of cycles, per side.
  int tx_idle_pct;
  int rx_idle_pct;

  // Stimulus-side copy of the periods, used only to shape time steps.
  logic [PERIOD_W-1:0] period_cfg [NUM_SLOTS];
  logic [NOW_W-1:0]    clock_ms;
  int                  span;

  periodic_task_due_scheduler_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  due_mask_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: drop ready at random on each falling edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Send one item. Entered just after a rising edge (or at the start); holds
  // valid until the item is taken and returns at that rising edge with valid
  // still high; between back-to-back items valid drops only on a random idle draw.
  task automatic send_item(input logic mode, input logic [NOW_W-1:0] now);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid  = 1'b1;
    req_ch.mode   = mode;
    req_ch.now_ms = now;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.addr  = addr;
    cfg_ch.data  = data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (addr < NUM_SLOTS) period_cfg[addr] = data;
  endtask

  // Load a new set of periods and pick the typical time step that goes with it.
  task automatic apply_setting(input period_set_t kind);
    logic [PERIOD_W-1:0] extremes [NUM_SLOTS];
    int rot;
    extremes = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'h8000};
    rot = $urandom_range(0, NUM_SLOTS - 1);
    drain();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      case (kind)
        SET_SMALL: begin
          write_reg(CFG_ADDR_W'(s), CFG_DATA_W'($urandom_range(1, 20)));
          span = 20;
        end
        SET_EXTREME: begin
          // rotate so every slot sees zero and the largest period over time
          write_reg(CFG_ADDR_W'(s), extremes[(s + rot) % NUM_SLOTS]);
          span = 8;
        end
        SET_FULL: begin
          write_reg(CFG_ADDR_W'(s), CFG_DATA_W'($urandom_range(0, 65535)));
          span = 65535;
        end
        default: begin
          write_reg(CFG_ADDR_W'(s), CFG_DATA_W'($urandom_range(1, 300)));
          span = 300;
        end
      endcase
    end
    // Hit one random index past the last slot; the block must ignore it.
    write_reg(CFG_ADDR_W'($urandom_range(NUM_SLOTS, 2**CFG_ADDR_W - 1)),
              CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  task automatic run_directed();
    logic [PERIOD_W-1:0] edge_periods [NUM_SLOTS];
    edge_periods = '{16'd0, 16'd1, 16'hFFFF, 16'hFFFE, 16'h8000};
    // Tick before any start: last-run times still zero, reset periods.
    send_item(MODE_TICK, 32'd0);
    send_item(MODE_TICK, 32'd9);
    send_item(MODE_TICK, 32'd10);
    send_item(MODE_TICK, 32'd99);
    send_item(MODE_TICK, 32'd100);
    send_item(MODE_TICK, 32'hFFFF_FFFF);
    // Start just below the wrap, then tick across it.
    send_item(MODE_START, 32'hFFFF_FFF8);
    send_item(MODE_TICK, 32'd2);
    send_item(MODE_TICK, 32'd92);
    send_item(MODE_START, 32'd0);
    send_item(MODE_START, 32'hFFFF_FFFF);
    // Zero period, period one and the largest periods.
    drain();
    for (int s = 0; s < NUM_SLOTS; s++) write_reg(CFG_ADDR_W'(s), edge_periods[s]);
    for (int a = NUM_SLOTS; a < 2**CFG_ADDR_W; a++)
      write_reg(CFG_ADDR_W'(a), (a % 2 == 0) ? 16'hFFFF : 16'h5A5A);
    send_item(MODE_START, 32'h1234_5678);
    send_item(MODE_TICK, 32'h1234_5678);
    send_item(MODE_TICK, 32'h1234_5679);
    send_item(MODE_TICK, 32'h1235_5679);
    send_item(MODE_TICK, 32'hAAAA_AAAA);
    send_item(MODE_TICK, 32'h5555_5555);
    send_item(MODE_START, 32'h5555_5555);
    send_item(MODE_TICK, 32'h5555_D555);
    clock_ms = 32'h5555_D555;
  endtask

  // Mostly a clock that moves forward in steps near the periods, so slots come
  // due now and then; some restarts, long jumps and arbitrary times as noise.
  task automatic run_random(input int count);
    int pick;
    logic [NOW_W-1:0] delta;
    logic [NOW_W-1:0] p;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < START_PCT) begin
        case ($urandom_range(2))
          0:       clock_ms = clock_ms + $urandom_range(0, span);
          1:       clock_ms = $urandom;
          default: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * span);
        endcase
        send_item(MODE_START, clock_ms);
      end else begin
        if (pick < 60) begin
          delta = $urandom_range(0, 2 * span);
        end else if (pick < 78) begin
          // land on whole periods of one slot
          p = NOW_W'(period_cfg[$urandom_range(0, NUM_SLOTS - 1)]);
          if (p == '0) p = NOW_W'(1);
          delta = p * $urandom_range(1, 3);
        end else if (pick < 90) begin
          delta = $urandom_range(0, 2);
        end else if (pick < 96) begin
          delta = $urandom;
        end else begin
          clock_ms = $urandom;
          delta = '0;
        end
        clock_ms = clock_ms + delta;
        send_item(MODE_TICK, clock_ms);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.mode   = MODE_TICK;
    req_ch.now_ms = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = '0;
    cfg_ch.data   = '0;
    tx_idle_pct   = 33;
    rx_idle_pct   = 50;
    period_cfg    = PERIOD_RESET;
    clock_ms      = '0;
    span          = 20;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();

    // Three idling phases, two period settings each.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 33; rx_idle_pct = 50; end
        1:       begin tx_idle_pct = 50; rx_idle_pct = 33; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        apply_setting(period_set_t'((phase * 2 + seg) % 4));
        run_random(SEGMENT_ITEMS);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
